>>> sv/positional_list_store_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the positional list store unit
// Shared property shorthands; define NO_ASSERTIONS to drop them all.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_UNIT_MACROS_SVH
`define POSITIONAL_LIST_STORE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset
`define PLS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("positional list store: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define PLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("positional list store: next-cycle check failed");

`else

`define PLS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define PLS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/pls_pkg.sv
// ----------------------------------------------------------------------------
// Positional list store package
// Operation and status codes, field widths and the per-cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package pls_pkg;

	// Default sizes
	localparam int CAPACITY_DEF   = 16;
	localparam int DATA_WIDTH_DEF = 32;

	// Request and result field widths
	localparam int OP_W    = 3;
	localparam int POS_W   = 6;
	localparam int VALUE_W = 32;
	localparam int DOUT_W  = 32;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 5;

	// Operation codes
	localparam logic [OP_W-1:0] OP_READ    = 3'd0;
	localparam logic [OP_W-1:0] OP_INSERT  = 3'd1;
	localparam logic [OP_W-1:0] OP_REMOVE  = 3'd2;
	localparam logic [OP_W-1:0] OP_RESTART = 3'd3;
	localparam logic [OP_W-1:0] OP_NEXT    = 3'd4;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_BAD  = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

	// Control for one cell of the row
	typedef struct packed {
		logic load;        // take the inserted value
		logic shift_up;    // take the left neighbour
		logic shift_down;  // take the right neighbour
	} cell_ctrl_t;

endpackage

`default_nettype wire

>>> sv/positional_list_store_unit.sv
// An ordered list of up to CAPACITY words kept in a row of cells, one entry
// per cell: insert, read, remove, restart traversal and traversal next, one
// request per clock. A request is taken when s_tvalid and s_tready are high
// and its result sits in the output register on the following cycle; the
// next request is taken in that same cycle unless the output is stalled.
// Insert and remove move every affected cell at once: each cell shifts its word
// to its neighbour in a single step. s_tuser[2:0] is the operation;
// s_tdata holds position[5:0] (two's complement) then value[37:6].
// m_tdata holds data_out[31:0] then count[36:32]; m_tuser[1:0] is status.
// Cells beyond the count are never read and need no clearing after reset.
`default_nettype none

`include "positional_list_store_unit_macros.svh"

module positional_list_store_unit #(
	parameter int CAPACITY   = pls_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = pls_pkg::DATA_WIDTH_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [39:0] s_tdata,   // position[5:0], value[37:6], zero pad
	input  wire  [2:0]  s_tuser,   // operation[2:0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,   // data_out[31:0], count[36:32], zero pad
	output logic [1:0]  m_tuser    // status[1:0]
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = CW + pls_pkg::POS_W + 1;

	// Request fields
	logic [pls_pkg::OP_W-1:0]    op;
	logic [pls_pkg::POS_W-1:0]   pos;
	logic [pls_pkg::VALUE_W-1:0] value;
	logic                        accept;

	assign op     = s_tuser;
	assign pos    = s_tdata[pls_pkg::POS_W-1:0];
	assign value  = s_tdata[pls_pkg::POS_W +: pls_pkg::VALUE_W];
	assign accept = s_tvalid && s_tready;

	// Control state
	logic [CW-1:0] count_q;
	logic [CW-1:0] cursor_q;
	logic          m_tvalid_q;

	// Result payload
	logic [pls_pkg::DOUT_W-1:0]  dout_q;
	logic [pls_pkg::STAT_W-1:0]  status_q;
	logic [pls_pkg::COUNT_W-1:0] count_out_q;

	// Position mapping
	logic signed [IW-1:0] pos_ext;
	logic signed [IW-1:0] cnt_ext;
	logic signed [IW-1:0] rd_p;
	logic signed [IW-1:0] ins_p;
	logic                 rd_ok;
	logic                 ins_ok;

	assign pos_ext = $signed({{(IW-pls_pkg::POS_W){pos[pls_pkg::POS_W-1]}}, pos});
	assign cnt_ext = $signed({{(IW-CW){1'b0}}, count_q});
	assign rd_p    = pos[pls_pkg::POS_W-1] ? (cnt_ext + pos_ext) : pos_ext;
	assign ins_p   = pos[pls_pkg::POS_W-1] ?
		(cnt_ext + pos_ext + $signed({{(IW-1){1'b0}}, 1'b1})) : pos_ext;
	assign rd_ok   = !rd_p[IW-1] && (rd_p < cnt_ext);
	assign ins_ok  = !ins_p[IW-1] && (ins_p <= cnt_ext);

	// Traversal
	logic [CW-1:0] cur;
	logic          trav_ok;

	assign cur     = (op == pls_pkg::OP_RESTART) ? '0 : cursor_q;
	assign trav_ok = cur < count_q;

	// Decode the request
	logic                        is_trav;
	logic                        full;
	logic                        ins_do;
	logic                        rem_do;
	logic [AW-1:0]               rd_idx;
	logic [AW-1:0]               ins_idx;
	logic [pls_pkg::STAT_W-1:0]  status_c;
	logic                        read_hit;

	assign is_trav = (op == pls_pkg::OP_RESTART) || (op == pls_pkg::OP_NEXT);
	assign full    = count_q >= CW'(CAPACITY);
	assign rd_idx  = is_trav ? cur[AW-1:0] : rd_p[AW-1:0];
	assign ins_idx = ins_p[AW-1:0];
	assign ins_do  = accept && (op == pls_pkg::OP_INSERT) && ins_ok && !full;
	assign rem_do  = accept && (op == pls_pkg::OP_REMOVE) && rd_ok;

	always_comb begin
		status_c = pls_pkg::ST_OK;
		read_hit = 1'b0;
		unique case (op)
			pls_pkg::OP_READ, pls_pkg::OP_REMOVE: begin
				status_c = rd_ok ? pls_pkg::ST_OK : pls_pkg::ST_BAD;
				read_hit = rd_ok;
			end
			pls_pkg::OP_INSERT: begin
				priority if (!ins_ok) begin
					status_c = pls_pkg::ST_BAD;
				end else if (full) begin
					status_c = pls_pkg::ST_FULL;
				end else begin
					status_c = pls_pkg::ST_OK;
				end
			end
			pls_pkg::OP_RESTART, pls_pkg::OP_NEXT: begin
				status_c = trav_ok ? pls_pkg::ST_OK : pls_pkg::ST_BAD;
				read_hit = trav_ok;
			end
			default: begin
				status_c = pls_pkg::ST_OK;
				read_hit = 1'b0;
			end
		endcase
	end

	// Row of cells
	logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
	logic [DATA_WIDTH-1:0] ins_value;

	assign ins_value = DATA_WIDTH'(value);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		pls_pkg::cell_ctrl_t   ctrl;
		logic [DATA_WIDTH-1:0] left_w;
		logic [DATA_WIDTH-1:0] right_w;

		assign ctrl.load       = ins_do && (AW'(i) == ins_idx);
		assign ctrl.shift_up   = ins_do && (AW'(i) > ins_idx);
		assign ctrl.shift_down = rem_do && (AW'(i) >= rd_idx);
		assign left_w  = (i == 0) ? cell_data[i] : cell_data[(i == 0) ? 0 : i-1];
		assign right_w = (i == CAPACITY-1) ? cell_data[i]
			: cell_data[(i == CAPACITY-1) ? i : i+1];

		pls_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.value     (ins_value),
			.left_data (left_w),
			.right_data(right_w),
			.data      (cell_data[i])
		);
	end

	// Select the addressed cell
	logic [DATA_WIDTH-1:0] rd_data;

	always_comb begin
		rd_data = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (AW'(i) == rd_idx) begin
				rd_data = cell_data[i];
			end
		end
	end

	// Next count
	logic [CW-1:0] count_d;

	always_comb begin
		count_d = count_q;
		priority if (ins_do) begin
			count_d = count_q + CW'(1);
		end else if (rem_do) begin
			count_d = count_q - CW'(1);
		end else begin
			count_d = count_q;
		end
	end

	// Advance count and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			cursor_q <= '0;
		end else if (accept) begin
			count_q <= count_d;
			if (is_trav) begin
				cursor_q <= trav_ok ? (cur + CW'(1)) : cur;
			end
		end
	end

	// Output register handshake
	assign s_tready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_tready) begin
			m_tvalid_q <= s_tvalid;
		end
	end

	// Capture the result
	always_ff @(posedge clk) begin
		if (accept) begin
			dout_q      <= read_hit ? pls_pkg::DOUT_W'(rd_data) : '0;
			status_q    <= status_c;
			count_out_q <= pls_pkg::COUNT_W'(count_d);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, count_out_q, dout_q};
	assign m_tuser  = status_q;

	// Checks
	`PLS_ASSERT_IMPLIES(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(CAPACITY))
	`PLS_ASSERT_NEXT(a_insert_keeps_cursor, clk, arst_n,
		accept && (op == pls_pkg::OP_INSERT), $stable(cursor_q))
	`PLS_ASSERT_NEXT(a_full_keeps_count, clk, arst_n,
		accept && (status_c == pls_pkg::ST_FULL), $stable(count_q))
	`PLS_ASSERT_NEXT(a_remove_drops_one, clk, arst_n,
		rem_do, count_q == $past(count_q) - CW'(1))

endmodule

`default_nettype wire

>>> sv/pls_cell.sv
// ----------------------------------------------------------------------------
// Positional list store cell
// One entry of the list; loads a new value or takes a neighbour's word.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_cell #(
	parameter int DATA_WIDTH = pls_pkg::DATA_WIDTH_DEF
) (
	input  wire                          clk,
	input  wire pls_pkg::cell_ctrl_t     ctrl,
	input  wire  [DATA_WIDTH-1:0]        value,
	input  wire  [DATA_WIDTH-1:0]        left_data,
	input  wire  [DATA_WIDTH-1:0]        right_data,
	output logic [DATA_WIDTH-1:0]        data
);

	logic [DATA_WIDTH-1:0] data_q;

	// Hold unless told to load or shift
	always_ff @(posedge clk) begin
		priority if (ctrl.load) begin
			data_q <= value;
		end else if (ctrl.shift_up) begin
			data_q <= left_data;
		end else if (ctrl.shift_down) begin
			data_q <= right_data;
		end else begin
			data_q <= data_q;
		end
	end

	assign data = data_q;

endmodule

`default_nettype wire

>>> verif/tb_positional_list_store_unit.sv
// ----------------------------------------------------------------------------
// Testbench for the positional list store unit
// Drives list requests (read, insert, remove, restart, next) through the
// stream slave port, predicts each result from a shadow copy of the list and
// checks every result beat field by field, with random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import pls_pkg::*;

// One expected result beat
typedef struct packed {
	logic [DOUT_W-1:0]  data_out;
	logic [STAT_W-1:0]  status;
	logic [COUNT_W-1:0] count;
} list_result_t;

// Shadow list plus the queue of results still owed by the block
class list_store_scoreboard;
	localparam int DEPTH = CAPACITY_DEF;

	logic [DOUT_W-1:0] cells [DEPTH];
	int                held_count;
	int                cursor;
	int                fail_count;
	list_result_t      awaited_results [$];

	function new();
		foreach (cells[i]) cells[i] = '0;
		held_count = 0;
		cursor     = 0;
		fail_count = 0;
	endfunction

	// Apply an accepted request to the shadow list and queue its result
	function void note_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos_raw,
			logic [VALUE_W-1:0] word);
		list_result_t r;
		int           p;
		int           i;
		r = '0;
		p = $signed(pos_raw);
		case (op)
			OP_READ, OP_REMOVE: begin
				// negative positions count back from the tail
				if (p < 0) p = held_count + p;
				if (p < 0 || p >= held_count) begin
					r.status = ST_BAD;
				end else begin
					r.data_out = cells[p];
					if (op == OP_REMOVE) begin
						for (i = p; i < held_count - 1; i++) cells[i] = cells[i + 1];
						held_count--;
					end
				end
			end
			OP_INSERT: begin
				// -1 appends, so the tail mapping is one further out
				if (p < 0) p = held_count + p + 1;
				if (p < 0 || p > held_count) begin
					r.status = ST_BAD;
				end else if (held_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					for (i = held_count; i > p; i--) cells[i] = cells[i - 1];
					cells[p] = word;
					held_count++;
				end
			end
			OP_RESTART, OP_NEXT: begin
				// the cursor is left alone once the walk has run off the end
				if (op == OP_RESTART) cursor = 0;
				if (cursor >= held_count) begin
					r.status = ST_BAD;
				end else begin
					r.data_out = cells[cursor];
					cursor++;
				end
			end
			default: ;
		endcase
		r.count = COUNT_W'(held_count);
		awaited_results.push_back(r);
	endfunction

	// Compare one result beat against the oldest owed result
	function void check_result(logic [39:0] beat, logic [STAT_W-1:0] flags);
		list_result_t want;
		list_result_t got;
		got.data_out = beat[31:0];
		got.count    = beat[36:32];
		got.status   = flags;
		if (awaited_results.size() == 0) begin
			$error("unexpected result: data_out %h status %0d count %0d",
				got.data_out, got.status, got.count);
			fail_count++;
			return;
		end
		want = awaited_results.pop_front();
		if (got.data_out !== want.data_out) begin
			$error("data_out mismatch: expected %h, actual %h", want.data_out, got.data_out);
			fail_count++;
		end
		if (got.status !== want.status) begin
			$error("status mismatch: expected %0d, actual %0d", want.status, got.status);
			fail_count++;
		end
		if (got.count !== want.count) begin
			$error("count mismatch: expected %0d, actual %0d", want.count, got.count);
			fail_count++;
		end
	endfunction
endclass

module tb_positional_list_store_unit;

	localparam int CYCLE_LIMIT = 200000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;

	list_store_scoreboard sb;
	bit                   steady_flow;
	int                   cycle_count;

	positional_list_store_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stall the result side at random unless in a steady stretch
	always @(posedge clk) begin
		m_tready <= steady_flow || ($urandom_range(0, 99) >= 31);
	end

	// Check every accepted result
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("positional_list_store_unit verification failed");
			$finish;
		end
	end

	// Offer one request, with random gaps before it, and hold until taken
	task automatic send_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
			logic [VALUE_W-1:0] word);
		while (!steady_flow && $urandom_range(0, 99) < 31) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {2'b00, word, pos};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_request(op, pos, word);
	endtask

	// Hold off the sender until every owed result has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.awaited_results.size() != 0) @(posedge clk);
	endtask

	// Weighted operation pick; a few unused codes mixed in as noise
	function automatic logic [OP_W-1:0] pick_operation(int ins_w, int rem_w, int rd_w,
			int trav_w);
		int x;
		if ($urandom_range(0, 99) < 3) return OP_W'($urandom_range(5, 7));
		x = $urandom_range(0, ins_w + rem_w + rd_w + trav_w - 1);
		if (x < ins_w) return OP_INSERT;
		x -= ins_w;
		if (x < rem_w) return OP_REMOVE;
		x -= rem_w;
		if (x < rd_w) return OP_READ;
		return ($urandom_range(0, 3) == 0) ? OP_RESTART : OP_NEXT;
	endfunction

	// Mostly legal positions for the current length, head- or tail-relative
	function automatic logic [POS_W-1:0] pick_position(logic [OP_W-1:0] op);
		int n;
		int p;
		n = sb.held_count;
		if ($urandom_range(0, 99) < 15) return POS_W'($urandom_range(0, 63));
		case (op)
			OP_INSERT: begin
				p = $urandom_range(0, n);
				if ($urandom_range(0, 1)) p = p - n - 1;
			end
			OP_READ, OP_REMOVE: begin
				if (n == 0) begin
					p = int'($urandom_range(0, 33)) - 17;
				end else begin
					p = $urandom_range(0, n - 1);
					if ($urandom_range(0, 1)) p = p - n;
				end
			end
			default: p = $urandom_range(0, 63);
		endcase
		return p[POS_W-1:0];
	endfunction

	// Random requests with a given operation mix
	task automatic run_segment(int items, int ins_w, int rem_w, int rd_w, int trav_w,
			bit steady);
		logic [OP_W-1:0] op;
		steady_flow = steady;
		repeat (items) begin
			op = pick_operation(ins_w, rem_w, rd_w, trav_w);
			send_request(op, pick_position(op), $urandom());
		end
		steady_flow = 1'b0;
	endtask

	initial begin
		sb          = new();
		cycle_count = 0;
		steady_flow = 1'b0;
		arst_n      <= 1'b0;
		s_tvalid    <= 1'b0;
		s_tdata     <= '0;
		s_tuser     <= '0;
		m_tready    <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty list: every access misses, walk ends at once
		send_request(OP_READ,    6'd0,  32'h1234_5678);
		send_request(OP_NEXT,    6'd0,  32'h0);
		send_request(OP_RESTART, 6'd0,  32'h0);
		send_request(OP_REMOVE,  -6'sd1, 32'h0);
		send_request(OP_INSERT,  6'd1,  32'hDEAD_BEEF);
		send_request(OP_INSERT,  -6'sd2, 32'hDEAD_BEEF);
		// Build four entries from both ends, extreme words
		send_request(OP_INSERT,  6'd0,  32'h0000_0000);
		send_request(OP_INSERT,  -6'sd1, 32'hFFFF_FFFF);
		send_request(OP_INSERT,  6'd0,  32'hA5A5_A5A5);
		send_request(OP_INSERT,  -6'sd4, 32'h5A5A_5A5A);
		// Position extremes on insert
		send_request(OP_INSERT,  6'b011111, 32'h1111_1111);
		send_request(OP_INSERT,  6'b100000, 32'h2222_2222);
		// Reads from the tail, and just past either end
		send_request(OP_READ,    -6'sd1, 32'h0);
		send_request(OP_READ,    -6'sd4, 32'h0);
		send_request(OP_READ,    -6'sd5, 32'h0);
		send_request(OP_READ,    6'd4,  32'h0);
		// Walk, remove under the cursor, then run off the end
		send_request(OP_RESTART, 6'd0,  32'h0);
		send_request(OP_NEXT,    6'd0,  32'h0);
		send_request(OP_REMOVE,  6'd1,  32'h0);
		send_request(OP_NEXT,    6'd0,  32'h0);
		send_request(OP_NEXT,    6'd0,  32'h0);
		// Unused codes must leave the list alone
		send_request(3'd5, 6'b111111, 32'hFFFF_FFFF);
		send_request(3'd6, 6'd0,      32'h0);
		send_request(3'd7, 6'b101010, 32'h8000_0001);
		send_request(OP_REMOVE, -6'sd1, 32'h0);

		// Fill up to full, then the long stretch without idling
		run_segment(60, 70, 5, 15, 10, 1'b0);
		run_segment(120, 30, 25, 25, 20, 1'b1);
		wait_drained();
		// Drain, walk-heavy traffic, then a general mix
		run_segment(60, 5, 70, 15, 10, 1'b0);
		run_segment(80, 25, 15, 10, 50, 1'b0);
		run_segment(180, 35, 30, 20, 15, 1'b0);

		wait_drained();
		repeat (8) @(posedge clk);
		if (sb.fail_count == 0) begin
			$display("positional_list_store_unit verification clean");
		end else begin
			$display("positional_list_store_unit verification failed");
		end
		$finish;
	end

endmodule
